[hdl/avs_pkg.sv]
// ----------------------------------------------------------------------------
// avs_pkg: shared types and constants of the ascending value sorter
// Capacity default, controller states and the links between sorter cells.
// ----------------------------------------------------------------------------
package avs_pkg;

   localparam int DEPTH_DEFAULT = 64;
   localparam int VALUE_W       = 32;

   typedef enum logic {
      ST_FILL  = 1'b0,
      ST_DRAIN = 1'b1
   } state_type;

   // what one cell shows its neighbors
   typedef struct packed {
      logic                       valid;
      logic                       lt;      // new value goes in front of this entry
      logic signed [VALUE_W-1:0]  value;
   } cell_link_type;

   // command broadcast to every cell
   typedef struct packed {
      logic insert;
      logic shift;
   } cell_cmd_type;

endpackage

[hdl/avs_cell.sv]
// ----------------------------------------------------------------------------
// avs_cell: one entry of the insertion sorter chain
// Holds one value; on insert takes its left neighbor's entry, the new value,
// or keeps its own; on shift takes its right neighbor's entry.
// ----------------------------------------------------------------------------
module avs_cell (
   input  logic                                 clock,
   input  logic                                 reset,
   input  avs_pkg::cell_cmd_type                cmd,
   input  logic signed [avs_pkg::VALUE_W-1:0]   new_value,
   input  avs_pkg::cell_link_type               left,
   input  avs_pkg::cell_link_type               right,
   output avs_pkg::cell_link_type               link_out
);

   logic                                 valid_ff, valid_in;
   logic signed [avs_pkg::VALUE_W-1:0]   value_ff, value_in;
   logic                                 lt;

   assign lt = !valid_ff || (new_value < value_ff);

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      if (cmd.shift) begin
         valid_in = right.valid;
         value_in = right.value;
      end else if (cmd.insert) begin
         if (left.lt) begin
            valid_in = left.valid;
            value_in = left.value;
         end else if (lt) begin
            valid_in = 1'b1;
            value_in = new_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign link_out = '{valid: valid_ff, lt: lt, value: value_ff};

endmodule

[hdl/ascending_value_sorter_core.sv]
// ----------------------------------------------------------------------------
// ascending_value_sorter_core: list sorter built from a chain of insert cells
// Collects a list of signed values and returns it in ascending order.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one signed 32-bit value per transfer, req_last marks the end
//   of a list. Each accepted value is placed in order at once, one transfer per
//   cycle while collecting, by a broadcast compare across the DEPTH cells of
//   the chain. Values beyond DEPTH are dropped and every result of that list
//   carries rsp_overflowed.
//   rsp channel: after the last value the list leaves from the head cell, one
//   value per cycle while rsp_ready is high, in ascending order; rsp_final_res
//   marks its last value. The first result is valid the cycle after the last
//   request transfer. req_ready stays low while a list is drained; the next
//   list is accepted once the final result has been transferred.
//   A stall on rsp_ready holds the chain and the head result unchanged.
//   Reset empties the chain, clears the count and overflow flag and returns
//   to collecting.
// ----------------------------------------------------------------------------
module ascending_value_sorter_core #(
   parameter int DEPTH = avs_pkg::DEPTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [avs_pkg::VALUE_W-1:0]   req_value,
   input  logic                                 req_last,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [avs_pkg::VALUE_W-1:0]   rsp_sorted_value,
   output logic                                 rsp_final_res,
   output logic                                 rsp_overflowed
);

   localparam int CW = $clog2(DEPTH + 1);

   avs_pkg::state_type      state_ff, state_in;
   logic [CW-1:0]           count_ff, count_in;
   logic                    overflow_ff, overflow_in;
   avs_pkg::cell_cmd_type   cmd;
   avs_pkg::cell_link_type  link [DEPTH];
   avs_pkg::cell_link_type  empty_link;
   logic                    req_xfer, rsp_xfer, full;

   assign empty_link = '{valid: 1'b0, lt: 1'b0, value: '0};

   assign full      = (count_ff == CW'(DEPTH));
   assign req_xfer  = req_valid && req_ready;
   assign rsp_xfer  = rsp_valid && rsp_ready;

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      overflow_in = overflow_ff;
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      cmd         = '{insert: 1'b0, shift: 1'b0};
      unique case (state_ff)
         avs_pkg::ST_FILL: begin
            req_ready = 1'b1;
            if (req_xfer) begin
               if (full) begin
                  overflow_in = 1'b1;
               end else begin
                  cmd.insert = 1'b1;
                  count_in   = count_ff + CW'(1);
               end
               if (req_last) begin
                  state_in = avs_pkg::ST_DRAIN;
               end
            end
         end
         avs_pkg::ST_DRAIN: begin
            rsp_valid = 1'b1;
            if (rsp_xfer) begin
               cmd.shift = 1'b1;
               count_in  = count_ff - CW'(1);
               if (rsp_final_res) begin
                  state_in    = avs_pkg::ST_FILL;
                  overflow_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = avs_pkg::ST_FILL;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= avs_pkg::ST_FILL;
         count_ff    <= '0;
         overflow_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         overflow_ff <= overflow_in;
      end
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      avs_pkg::cell_link_type left_link, right_link;
      if (i == 0) begin : g_head
         assign left_link = empty_link;
      end else begin : g_body
         assign left_link = link[i-1];
      end
      if (i == DEPTH - 1) begin : g_tail
         assign right_link = empty_link;
      end else begin : g_inner
         assign right_link = link[i+1];
      end
      avs_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .new_value (req_value),
         .left      (left_link),
         .right     (right_link),
         .link_out  (link[i])
      );
   end

   assign rsp_sorted_value = link[0].value;
   assign rsp_final_res    = (count_ff == CW'(1));
   assign rsp_overflowed   = overflow_ff;

   a_head_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> link[0].valid)
      else $error("result offered from an empty head cell");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("fill count beyond capacity");

   a_empty_chain: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> !link[0].valid)
      else $error("head cell valid with zero count");

   a_ordered: assert property (@(posedge clock) disable iff (reset)
      (link[0].valid && link[1].valid) |-> (link[0].value <= link[1].value))
      else $error("head entries out of order");

   a_back_to_fill: assert property (@(posedge clock) disable iff (reset)
      (rsp_xfer && rsp_final_res) |=> (req_ready && !rsp_valid))
      else $error("not collecting after final transfer");

endmodule
